### design/kpq_pkg.sv
// Package of shared constants, codes and types for the keyed packet queue.
`timescale 1ns / 1ps

package kpq_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int ACT_W  = 3;
  localparam int ADDR_W = 32;
  localparam int HDL_W  = 16;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;
  localparam int DATA_W = ADDR_W + HDL_W;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ENQUEUE = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DROP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEQUEUE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIND    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_COUNT   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS  = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

endpackage

### design/keyed_packet_queue.sv
// Top level of the keyed packet queue: entry memory and its scan/shift sequencer.
`timescale 1ns / 1ps

// Ordered queue of {destination, handle} entries with search and removal by key.
// Input channel (in_*): one beat carries an action and its operands. Output
// channel (out_*): one beat per action with status, handle, count and the
// occupancy after the action.
// Entries live in a single memory with one write and one registered read port.
// Enqueue, a rejected drop, an unknown code and a search of an empty queue
// skip the scan and go straight to the response state. Find and count read
// one entry per cycle and compare each entry in the cycle after its read;
// find stops at the first hit. Drop moves one entry per cycle one place down
// to close the gap. Dequeue scans like find, then moves the entries above the
// hit down. One action is in flight at a time; the next beat can be taken in
// the cycle after the result register loads, even while that result still
// waits.
// Reset empties the queue (fill level to zero) and clears the output valid;
// the memory content is left as is and is never read before it is written.
// A stalled receiver holds the result in the output register; the sequencer
// then waits with the next result until that register is free.
module keyed_packet_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kpq_pkg::ACT_W-1:0]     in_action,
  input  logic [kpq_pkg::ADDR_W-1:0]    in_dest_addr,
  input  logic [kpq_pkg::HDL_W-1:0]     in_packet_handle,
  input  logic [kpq_pkg::POS_W-1:0]     in_drop_position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kpq_pkg::STAT_W-1:0]    out_status,
  output logic [kpq_pkg::HDL_W-1:0]     out_found_handle,
  output logic [kpq_pkg::OCC_W-1:0]     out_match_count,
  output logic [kpq_pkg::OCC_W-1:0]     out_occupancy
);
  import kpq_pkg::*;

  // Entry memory
  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic              mem_re;
  logic [PTR_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [PTR_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;

  // Sequencer state
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [PTR_W-1:0]  pidx_r, pidx_nxt;
  logic [PTR_W-1:0]  wa_r, wa_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [ADDR_W-1:0] dst_r, dst_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [HDL_W-1:0]  got_r, got_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [HDL_W-1:0]  out_handle_r, out_handle_nxt;
  logic [OCC_W-1:0]  out_count_r, out_count_nxt;
  logic [OCC_W-1:0]  out_occ_r, out_occ_nxt;

  logic issue;
  logic hit;

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_handle = out_handle_r;
  assign out_match_count  = out_count_r;
  assign out_occupancy    = out_occ_r;

  // Read the next entry while it lies below the fill level
  assign issue = (idx_r < fill_r);
  // Compare the entry that came back from the last read
  assign hit   = pend_r && (rd_data_r[DATA_W-1:HDL_W] == dst_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    wa_nxt         = wa_r;
    act_nxt        = act_r;
    dst_nxt        = dst_r;
    status_nxt     = status_r;
    got_nxt        = got_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;
    out_count_nxt  = out_count_r;
    out_occ_nxt    = out_occ_r;
    mem_re         = 1'b0;
    rd_addr        = '0;
    mem_we         = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;

    // Drop the result beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt    = in_action;
          dst_nxt    = in_dest_addr;
          status_nxt = ST_OK;
          got_nxt    = '0;
          cnt_nxt    = '0;
          pend_nxt   = 1'b0;
          state_nxt  = S_RESP;
          unique case (in_action) inside
            ACT_ENQUEUE: begin
              if (fill_r == CNT_W'(QUEUE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we   = 1'b1;
                wr_addr  = fill_r[PTR_W-1:0];
                wr_data  = {in_dest_addr, in_packet_handle};
                fill_nxt = fill_r + 1'b1;
              end
            end
            ACT_DROP: begin
              if (CMP_W'(in_drop_position) >= CMP_W'(fill_r)) begin
                status_nxt = ST_BADPOS;
              end else begin
                wa_nxt    = PTR_W'(in_drop_position);
                idx_nxt   = CNT_W'(in_drop_position) + 1'b1;
                state_nxt = S_SHIFT;
              end
            end
            ACT_DEQUEUE, ACT_FIND, ACT_COUNT: begin
              if (fill_r == '0) begin
                if (in_action != ACT_COUNT) begin
                  status_nxt = ST_NOMATCH;
                end
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Stream reads, compare each entry in the cycle after its read
        if (issue) begin
          mem_re  = 1'b1;
          rd_addr = idx_r[PTR_W-1:0];
          idx_nxt = idx_r + 1'b1;
        end
        pend_nxt = issue;
        pidx_nxt = idx_r[PTR_W-1:0];
        if (hit && act_r != ACT_COUNT) begin
          if (act_r == ACT_DEQUEUE) begin
            // The read now in flight is the entry just above the hit
            got_nxt   = rd_data_r[HDL_W-1:0];
            wa_nxt    = pidx_r;
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_RESP;
          end
        end else begin
          if (hit) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (!issue) begin
            if (act_r != ACT_COUNT) begin
              status_nxt = ST_NOMATCH;
            end
            state_nxt = S_RESP;
          end
        end
      end

      S_SHIFT: begin
        // Move the entry read last cycle one place down
        if (pend_r) begin
          mem_we  = 1'b1;
          wr_addr = wa_r;
          wr_data = rd_data_r;
          wa_nxt  = wa_r + 1'b1;
        end
        if (issue) begin
          mem_re   = 1'b1;
          rd_addr  = idx_r[PTR_W-1:0];
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          fill_nxt  = fill_r - 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        // Load the output register when it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_handle_nxt = got_r;
          out_count_nxt  = OCC_W'(cnt_r);
          out_occ_nxt    = OCC_W'(fill_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pidx_r       <= pidx_nxt;
    wa_r         <= wa_nxt;
    act_r        <= act_nxt;
    dst_r        <= dst_nxt;
    status_r     <= status_nxt;
    got_r        <= got_nxt;
    cnt_r        <= cnt_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_count_r  <= out_count_nxt;
    out_occ_r    <= out_occ_nxt;
  end

endmodule

### design/kpq_checker.sv
// Port-level checker for the keyed packet queue, bound to the top level.
`timescale 1ns / 1ps

module kpq_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kpq_pkg::STAT_W-1:0]    out_status,
  input logic [kpq_pkg::HDL_W-1:0]     out_found_handle,
  input logic [kpq_pkg::OCC_W-1:0]     out_match_count,
  input logic [kpq_pkg::OCC_W-1:0]     out_occupancy
);
  import kpq_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found_handle) && $stable(out_match_count) && $stable(out_occupancy))
    else $error("stalled result beat changed");

  // One action at a time: no beat taken right after another
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an action is in flight");

  // Occupancy never exceeds the queue depth
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_occupancy <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // Full is reported only with a full queue
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_occupancy == OCC_W'(QUEUE_DEPTH))
    else $error("full status with free slots");

  // A handle comes back only with an ok status
  a_handle_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_handle != '0 |-> out_status == ST_OK)
    else $error("handle returned with an error status");

endmodule

bind keyed_packet_queue kpq_checker u_kpq_checker (.*);

### tb/keyed_packet_queue_tb.sv
// Self-checking testbench for the keyed packet queue: directed, fill/drain and random actions.
`timescale 1ns / 1ps

module keyed_packet_queue_tb;
  import kpq_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
  localparam int IDLE_PCT    = 27;
  localparam int MAX_REPORTS = 10;
  localparam int POS_MAX     = (1 << POS_W) - 1;
  localparam int ACT_MAX     = (1 << ACT_W) - 1;
  localparam int POOL_SIZE   = 6;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [HDL_W-1:0]  handle;
  } entry_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HDL_W-1:0]  handle;
    logic [OCC_W-1:0]  count;
    logic [OCC_W-1:0]  occ;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACT_W-1:0]    in_action = ACT_FIND;
  logic [ADDR_W-1:0]   in_dest_addr = '0;
  logic [HDL_W-1:0]    in_packet_handle = '0;
  logic [POS_W-1:0]    in_drop_position = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STAT_W-1:0]   out_status;
  logic [HDL_W-1:0]    out_found_handle;
  logic [OCC_W-1:0]    out_match_count;
  logic [OCC_W-1:0]    out_occupancy;

  // Predicted queue content, oldest first, and replies still owed by the block
  entry_t            held_q[$];
  reply_t            owed_q[$];
  logic [ADDR_W-1:0] dest_pool[POOL_SIZE];
  bit                idle_on = 1'b1;
  int                mismatches = 0;
  int                beats_seen = 0;
  int                cycle_cnt = 0;

  keyed_packet_queue i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_dest_addr     (in_dest_addr),
    .in_packet_handle (in_packet_handle),
    .in_drop_position (in_drop_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found_handle (out_found_handle),
    .out_match_count  (out_match_count),
    .out_occupancy    (out_occupancy)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("keyed_packet_queue_tb: FAIL");
      $finish;
    end
  end

  // Stall the result channel at random while idling is enabled
  always @(posedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
  end

  // Apply one action to the predicted queue and record the reply it owes
  function automatic void predict_reply(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] dest,
                                        logic [HDL_W-1:0] handle, logic [POS_W-1:0] pos);
    reply_t r;
    entry_t e;
    int     hit_at;
    r = '0;
    hit_at = -1;
    for (int k = 0; k < held_q.size(); k++) begin
      if (held_q[k].dest == dest) begin
        if (hit_at < 0) hit_at = k;
        r.count = r.count + 1'b1;
      end
    end
    case (act)
      ACT_ENQUEUE: begin
        if (held_q.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          e.dest = dest;
          e.handle = handle;
          held_q = {held_q, e};
        end
      end
      ACT_DROP: begin
        if (pos >= held_q.size()) r.status = ST_BADPOS;
        else held_q.delete(pos);
      end
      ACT_DEQUEUE: begin
        if (hit_at < 0) begin
          r.status = ST_NOMATCH;
        end else begin
          r.handle = held_q[hit_at].handle;
          held_q.delete(hit_at);
        end
      end
      ACT_FIND: begin
        if (hit_at < 0) r.status = ST_NOMATCH;
      end
      default: ;
    endcase
    // Only count reports the number of matches
    if (act != ACT_COUNT) r.count = '0;
    r.occ = OCC_W'(held_q.size());
    owed_q = {owed_q, r};
  endfunction

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $realtime, msg);
  endfunction

  function automatic void check_field(string name, int beat, logic [31:0] want,
                                      logic [31:0] got);
    if (got !== want)
      flag_mismatch($sformatf("beat %0d %s expected 0x%0h got 0x%0h", beat, name, want, got));
  endfunction

  // Compare every result beat with the oldest owed reply
  always @(posedge clk) begin : check_beats
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_q.size() == 0) begin
        flag_mismatch($sformatf("beat %0d arrived with no reply owed", beats_seen));
      end else begin
        want = owed_q.pop_front();
        check_field("status", beats_seen, 32'(want.status), 32'(out_status));
        check_field("found_handle", beats_seen, 32'(want.handle), 32'(out_found_handle));
        check_field("match_count", beats_seen, 32'(want.count), 32'(out_match_count));
        check_field("occupancy", beats_seen, 32'(want.occ), 32'(out_occupancy));
      end
      beats_seen++;
    end
  end

  // Drive one beat, hold it until accepted, then predict its reply
  task automatic send_beat(logic [ACT_W-1:0] act, logic [ADDR_W-1:0] dest,
                           logic [HDL_W-1:0] handle, logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_dest_addr     <= dest;
    in_packet_handle <= handle;
    in_drop_position <= pos;
    do @(posedge clk); while (!in_ready);
    predict_reply(act, dest, handle, pos);
  endtask

  // Mostly addresses already queued or from a small pool, so matches are common
  function automatic logic [ADDR_W-1:0] pick_dest();
    int roll;
    roll = $urandom_range(99);
    if (held_q.size() > 0 && roll < 55) return held_q[$urandom_range(held_q.size() - 1)].dest;
    if (roll < 85) return dest_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Extremes of every field, each action and each special case on a small queue
  task automatic test_directed();
    send_beat(ACT_FIND, '0, '0, '0);
    send_beat(ACT_COUNT, '0, '0, '0);
    send_beat(ACT_DEQUEUE, '1, '1, '0);
    send_beat(ACT_DROP, '0, '0, '0);
    send_beat(ACT_ENQUEUE, '0, '0, '0);
    send_beat(ACT_ENQUEUE, '1, '1, POS_W'(POS_MAX));
    send_beat(ACT_ENQUEUE, 32'h0A00_0001, 16'h5A5A, '0);
    send_beat(ACT_ENQUEUE, '0, 16'hA5A5, '0);
    send_beat(ACT_FIND, '0, '0, '0);
    send_beat(ACT_FIND, '1, '0, '0);
    send_beat(ACT_FIND, 32'h0A00_0002, '0, '0);
    send_beat(ACT_COUNT, '0, '1, POS_W'(POS_MAX));
    send_beat(ACT_COUNT, 32'h0A00_0002, '0, '0);
    // Oldest match leaves first
    send_beat(ACT_DEQUEUE, '0, '0, '0);
    send_beat(ACT_COUNT, '0, '0, '0);
    send_beat(ACT_DROP, '0, '0, POS_W'(POS_MAX));
    send_beat(ACT_DROP, '0, '0, 4'd1);
    send_beat(ACT_DEQUEUE, 32'h0A00_0002, '0, '0);
    for (int a = ACT_COUNT + 1; a <= ACT_MAX; a++)
      send_beat(ACT_W'(a), '1, '1, POS_W'(POS_MAX));
    send_beat(ACT_DEQUEUE, '1, '0, '0);
    send_beat(ACT_DEQUEUE, '0, '0, '0);
  endtask

  // Fill to capacity, push against full, then drain with mixed removals
  task automatic test_fill_drain(int rounds);
    for (int r = 0; r < rounds; r++) begin
      while (held_q.size() < QUEUE_DEPTH)
        send_beat(ACT_ENQUEUE, pick_dest(), HDL_W'($urandom), POS_W'($urandom));
      send_beat(ACT_ENQUEUE, $urandom, HDL_W'($urandom), POS_W'($urandom));
      send_beat(ACT_ENQUEUE, pick_dest(), HDL_W'($urandom), POS_W'($urandom));
      for (int p = 0; p < POOL_SIZE; p++)
        send_beat(ACT_COUNT, dest_pool[p], HDL_W'($urandom), POS_W'($urandom));
      send_beat(ACT_DROP, $urandom, HDL_W'($urandom), POS_W'(POS_MAX));
      send_beat(ACT_DROP, $urandom, HDL_W'($urandom), POS_W'(held_q.size()));
      while (held_q.size() > 0) begin
        if ($urandom_range(1))
          send_beat(ACT_DEQUEUE, pick_dest(), HDL_W'($urandom), POS_W'($urandom));
        else
          send_beat(ACT_DROP, $urandom, HDL_W'($urandom),
                    POS_W'($urandom_range(held_q.size() - 1)));
      end
      send_beat(ACT_DEQUEUE, pick_dest(), HDL_W'($urandom), POS_W'($urandom));
      send_beat(ACT_FIND, pick_dest(), HDL_W'($urandom), POS_W'($urandom));
      send_beat(ACT_DROP, $urandom, HDL_W'($urandom), '0);
    end
  endtask

  // Random actions steered toward a fill target that moves now and then
  task automatic test_random(int n_items);
    int target;
    target = 0;
    for (int i = 0; i < n_items; i++) begin
      int               roll;
      int               enq_pct;
      logic [ACT_W-1:0] act;
      logic [POS_W-1:0] pos;
      if (i % 48 == 0) begin
        roll = $urandom_range(9);
        target = (roll < 3) ? QUEUE_DEPTH : (roll < 5) ? 0 : $urandom_range(QUEUE_DEPTH);
      end
      enq_pct = (held_q.size() < target) ? 65 : (target == QUEUE_DEPTH) ? 40 : 15;
      roll = $urandom_range(99);
      if (roll < enq_pct) begin
        act = ACT_ENQUEUE;
      end else if (roll >= 97) begin
        act = ACT_W'($urandom_range(ACT_COUNT + 1, ACT_MAX));
      end else begin
        case ($urandom_range(3))
          0: act = ACT_DROP;
          1: act = ACT_DEQUEUE;
          2: act = ACT_FIND;
          default: act = ACT_COUNT;
        endcase
      end
      if (act == ACT_DROP && held_q.size() > 0 && $urandom_range(99) < 70)
        pos = POS_W'($urandom_range(held_q.size() - 1));
      else
        pos = POS_W'($urandom_range(POS_MAX));
      send_beat(act, pick_dest(), HDL_W'($urandom), pos);
    end
  endtask

  initial begin
    dest_pool[0] = '0;
    dest_pool[1] = '1;
    for (int p = 2; p < POOL_SIZE; p++) dest_pool[p] = $urandom;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_drain(3);
    // Long stretch with both sides always ready
    idle_on = 1'b0;
    test_random(400);
    idle_on = 1'b1;
    test_random(900);
    in_valid <= 1'b0;

    // Drain outstanding replies, then watch for stray beats
    while (owed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("keyed_packet_queue_tb: PASS");
    end else begin
      $display("keyed_packet_queue_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/kpq_pkg.sv
design/keyed_packet_queue.sv
design/kpq_checker.sv
tb/keyed_packet_queue_tb.sv
